// ===== src/tlis_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlis_pkg
// Shared types, command codes and character constants for the tape language
// instruction step block.
// ----------------------------------------------------------------------------
package tlis_pkg;

  localparam int PROG_DEPTH_DEF = 2048;
  localparam int DATA_DEPTH_DEF = 32768;
  localparam int CELL_BITS_DEF  = 8;

  localparam int PC_NOW_W = 11;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_STEP    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] prog_addr;
    logic [7:0]  prog_byte;
    logic [7:0]  in_byte;
  } in_t;

  typedef struct packed {
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                input_used;
    logic                halted;
    logic                fault;
    logic [PC_NOW_W-1:0] pc_now;
  } out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_start;
    logic scan_more;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/tlis_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlis_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/tlis_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlis_ctrl
// Sequencer for clearing, execution, bracket scans and the result handshake.
// ----------------------------------------------------------------------------
module tlis_ctrl import tlis_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready  = (state == S_IDLE);
  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.accept = (state == S_IDLE) && req_valid;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.emit   = (state == S_STAT) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = sts.scan_start ? S_SCAN : S_STAT;
      end
      S_SCAN: begin
        state_next = sts.scan_more ? S_SCAN : S_STAT;
      end
      S_STAT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/tlis_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlis_dp
// Datapath: program and cell memories, pointers, bracket scanner and the
// result register.
// ----------------------------------------------------------------------------
module tlis_dp import tlis_pkg::*; #(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire in_t  req,
  output sts_t      sts,
  output out_t      rsp
);

  localparam int PA_W      = $clog2(PROG_DEPTH);
  localparam int DA_W      = $clog2(DATA_DEPTH);
  localparam int CLR_DEPTH = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int DEP_W     = PA_W + 1;

  logic [PA_W-1:0]      pc;
  logic [PA_W-1:0]      pc_d;
  logic [DA_W-1:0]      dp;
  logic [DA_W-1:0]      dp_d;
  logic [PA_W-1:0]      scan_addr;
  logic [PA_W-1:0]      scan_addr_d;
  logic [DEP_W-1:0]     depth;
  logic [DEP_W-1:0]     depth_d;
  logic                 scan_fwd;
  logic                 scan_fwd_d;
  logic                 ov_q;
  logic                 ov_d;
  logic [7:0]           ob_q;
  logic [7:0]           ob_d;
  logic                 iu_q;
  logic                 iu_d;
  logic                 fault_q;
  logic                 fault_d;
  logic [CLR_W-1:0]     clr_cnt;
  in_t                  req_q;

  logic                 prog_we;
  logic [PA_W-1:0]      prog_waddr;
  logic [7:0]           prog_wdata;
  logic [PA_W-1:0]      prog_raddr;
  logic [7:0]           prog_rdata;
  logic                 cell_we;
  logic                 cell_we_c;
  logic [DA_W-1:0]      cell_waddr;
  logic [CELL_BITS-1:0] cell_wdata;
  logic [CELL_BITS-1:0] cell_wdata_c;
  logic [CELL_BITS-1:0] cell_rdata;
  logic                 load_in_range;

  function automatic logic [PA_W-1:0] pc_inc(input logic [PA_W-1:0] p);
    return (p == PA_W'(PROG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign load_in_range = (32'(req.prog_addr) < 32'(PROG_DEPTH));

  always_comb begin
    pc_d         = pc;
    dp_d         = dp;
    scan_addr_d  = scan_addr;
    depth_d      = depth;
    scan_fwd_d   = scan_fwd;
    cell_we_c    = 1'b0;
    cell_wdata_c = cell_rdata;
    ov_d         = ov_q;
    ob_d         = ob_q;
    iu_d         = iu_q;
    fault_d      = fault_q;
    sts.clear_last = (clr_cnt == CLR_W'(CLR_DEPTH - 1));
    sts.scan_start = 1'b0;
    sts.scan_more  = 1'b0;

    if (cmd.accept) begin
      ov_d    = 1'b0;
      ob_d    = '0;
      iu_d    = 1'b0;
      fault_d = 1'b0;
    end

    if (cmd.exec) begin
      unique case (req_q.req_type)
        REQ_RESTART: begin
          pc_d = '0;
        end
        REQ_STEP: begin
          if (prog_rdata != '0) begin
            unique case (prog_rdata)
              CH_RIGHT: begin
                dp_d = (dp == DA_W'(DATA_DEPTH - 1)) ? '0 : dp + 1'b1;
                pc_d = pc_inc(pc);
              end
              CH_LEFT: begin
                dp_d = (dp == '0) ? DA_W'(DATA_DEPTH - 1) : dp - 1'b1;
                pc_d = pc_inc(pc);
              end
              CH_INC: begin
                cell_we_c    = 1'b1;
                cell_wdata_c = cell_rdata + 1'b1;
                pc_d         = pc_inc(pc);
              end
              CH_DEC: begin
                cell_we_c    = 1'b1;
                cell_wdata_c = cell_rdata - 1'b1;
                pc_d         = pc_inc(pc);
              end
              CH_OUT: begin
                ov_d = 1'b1;
                ob_d = cell_rdata[7:0];
                pc_d = pc_inc(pc);
              end
              CH_IN: begin
                iu_d         = 1'b1;
                cell_we_c    = 1'b1;
                cell_wdata_c = CELL_BITS'(req_q.in_byte);
                pc_d         = pc_inc(pc);
              end
              CH_OPEN: begin
                if (cell_rdata != '0) begin
                  pc_d = pc_inc(pc);
                end else if (pc == PA_W'(PROG_DEPTH - 1)) begin
                  fault_d = 1'b1;
                end else begin
                  sts.scan_start = 1'b1;
                  scan_addr_d    = pc + 1'b1;
                  scan_fwd_d     = 1'b1;
                  depth_d        = DEP_W'(1);
                end
              end
              CH_CLOSE: begin
                if (pc == '0) begin
                  fault_d = 1'b1;
                end else begin
                  sts.scan_start = 1'b1;
                  scan_addr_d    = pc - 1'b1;
                  scan_fwd_d     = 1'b0;
                  depth_d        = DEP_W'(1);
                end
              end
              default: begin
                pc_d = pc_inc(pc);
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan) begin
      if (scan_fwd) begin
        if (prog_rdata == '0) begin
          fault_d = 1'b1;
        end else if ((prog_rdata == CH_CLOSE) && (depth == DEP_W'(1))) begin
          pc_d = pc_inc(scan_addr);
        end else begin
          if (prog_rdata == CH_OPEN) begin
            depth_d = depth + 1'b1;
          end else if (prog_rdata == CH_CLOSE) begin
            depth_d = depth - 1'b1;
          end
          if (scan_addr == PA_W'(PROG_DEPTH - 1)) begin
            fault_d = 1'b1;
          end else begin
            sts.scan_more = 1'b1;
            scan_addr_d   = scan_addr + 1'b1;
          end
        end
      end else begin
        if ((prog_rdata == CH_OPEN) && (depth == DEP_W'(1))) begin
          pc_d = scan_addr;
        end else begin
          if (prog_rdata == CH_CLOSE) begin
            depth_d = depth + 1'b1;
          end else if (prog_rdata == CH_OPEN) begin
            depth_d = depth - 1'b1;
          end
          if (scan_addr == '0) begin
            fault_d = 1'b1;
          end else begin
            sts.scan_more = 1'b1;
            scan_addr_d   = scan_addr - 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (cmd.clear) begin
      prog_we    = (32'(clr_cnt) < 32'(PROG_DEPTH));
      prog_waddr = clr_cnt[PA_W-1:0];
      prog_wdata = '0;
      cell_we    = (32'(clr_cnt) < 32'(DATA_DEPTH));
      cell_waddr = clr_cnt[DA_W-1:0];
      cell_wdata = '0;
    end else begin
      prog_we    = cmd.accept && (req.req_type == REQ_LOAD) && load_in_range;
      prog_waddr = PA_W'(req.prog_addr);
      prog_wdata = req.prog_byte;
      cell_we    = cmd.exec && cell_we_c;
      cell_waddr = dp;
      cell_wdata = cell_wdata_c;
    end
  end

  assign prog_raddr = ((cmd.exec && sts.scan_start) || (cmd.scan && sts.scan_more)) ?
                      scan_addr_d : pc_d;

  tlis_ram #(
    .WIDTH(8),
    .DEPTH(PROG_DEPTH)
  ) u_prog_ram (
    .clk  (clk),
    .we   (prog_we),
    .waddr(prog_waddr),
    .wdata(prog_wdata),
    .raddr(prog_raddr),
    .rdata(prog_rdata)
  );

  tlis_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(DATA_DEPTH)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cell_we),
    .waddr(cell_waddr),
    .wdata(cell_wdata),
    .raddr(dp),
    .rdata(cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      dp      <= '0;
      clr_cnt <= '0;
    end else begin
      pc <= pc_d;
      dp <= dp_d;
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
    scan_addr <= scan_addr_d;
    depth     <= depth_d;
    scan_fwd  <= scan_fwd_d;
    ov_q      <= ov_d;
    ob_q      <= ob_d;
    iu_q      <= iu_d;
    fault_q   <= fault_d;
    if (cmd.emit) begin
      rsp.out_valid  <= ov_q;
      rsp.out_byte   <= ob_q;
      rsp.input_used <= iu_q;
      rsp.halted     <= (prog_rdata == '0);
      rsp.fault      <= fault_q;
      rsp.pc_now     <= PC_NOW_W'(pc);
    end
  end

endmodule
`default_nettype wire

// ===== src/tape_language_instruction_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tape_language_instruction_step
// A transaction is accepted in the idle state and executed in the exec state
// from the registered reads of the program and cell memories; its result is
// registered when the status state emits it, and no new transaction is taken
// until then. A bracket scan adds a scan state with one program memory read
// per program byte visited. A clearing pass after reset over max(PROG_DEPTH,
// DATA_DEPTH) addresses zeroes both memories; none is accepted until it ends.
// ----------------------------------------------------------------------------
module tape_language_instruction_step import tlis_pkg::*; #(
  parameter int PROG_DEPTH = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire in_t  req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output out_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  tlis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlis_dp #(
    .PROG_DEPTH(PROG_DEPTH),
    .DATA_DEPTH(DATA_DEPTH),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .req(req),
    .sts(sts),
    .rsp(rsp)
  );

endmodule
`default_nettype wire
